>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks used by the predictor checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> sv/cbp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbp_pkg
// shared constants and types of the correlating branch predictor
// ---------------------------------------------------------------------------
package cbp_pkg;

	localparam int CBP_ADDR_WIDTH_MAX = 10;
	localparam int CBP_HIST_WIDTH_MAX = 4;

	localparam int BR_ADDR_W  = 32;
	localparam int COUNT_W    = 32;
	localparam int ENTRIES_W  = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// table entry: touched mark above, two-bit counter below
	localparam int CTR_W   = 2;
	localparam int ENTRY_W = CTR_W + 1;

	localparam int OUT_Q_DEPTH = 3;
	localparam int OUT_Q_CNT_W = 2;

	localparam logic [CTR_W-1:0] CTR_STRONG_NT = 2'd0;
	localparam logic [CTR_W-1:0] CTR_WEAK_NT   = 2'd1;
	localparam logic [CTR_W-1:0] CTR_WEAK_T    = 2'd2;
	localparam logic [CTR_W-1:0] CTR_STRONG_T  = 2'd3;

	localparam logic       MODE_ONE_BIT = 1'b0;
	localparam logic       MODE_TWO_BIT = 1'b1;
	localparam logic [2:0] HIST_BITS_RESET = 3'd4;
	localparam logic [3:0] ADDR_BITS_RESET = 4'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COUNTER_MODE = 2'd0,
		CFG_HISTORY_BITS = 2'd1,
		CFG_ADDR_BITS    = 2'd2
	} cbp_cfg_idx_t;

	typedef struct packed {
		logic       counter_mode;
		logic [2:0] history_bits;
		logic [3:0] addr_bits;
	} cbp_cfg_t;

	typedef struct packed {
		logic                 predicted_taken;
		logic [COUNT_W-1:0]   correct_count;
		logic [COUNT_W-1:0]   total_count;
		logic [ENTRIES_W-1:0] entries_used;
	} cbp_result_t;

endpackage

>>> sv/cbp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbp interfaces
// valid/ready channels for branches, results and configuration writes
// ---------------------------------------------------------------------------
interface cbp_branch_if import cbp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [BR_ADDR_W-1:0] branch_address;
	logic                 taken;

	modport source (output valid, branch_address, taken, input ready);
	modport sink (input valid, branch_address, taken, output ready);
endinterface

interface cbp_result_if import cbp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 predicted_taken;
	logic [COUNT_W-1:0]   correct_count;
	logic [COUNT_W-1:0]   total_count;
	logic [ENTRIES_W-1:0] entries_used;

	modport source (output valid, predicted_taken, correct_count, total_count, entries_used,
		input ready);
	modport sink (input valid, predicted_taken, correct_count, total_count, entries_used,
		output ready);
endinterface

interface cbp_cfg_if import cbp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> sv/cbp_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbp_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module cbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/cbp_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbp_front
// config registers, global history, table index and the clearing pass
// ---------------------------------------------------------------------------
module cbp_front import cbp_pkg::*; #(
	parameter int ADDR_WIDTH_MAX = CBP_ADDR_WIDTH_MAX,
	parameter int HIST_WIDTH_MAX = CBP_HIST_WIDTH_MAX,
	parameter int IDX_W = ADDR_WIDTH_MAX + HIST_WIDTH_MAX
) (
	input  logic              clk,
	input  logic              arst_n,
	cbp_cfg_if.sink           cfg,
	cbp_branch_if.sink        branch,
	input  logic              space_ok,
	output cbp_cfg_t          cfg_o,
	output logic [IDX_W-1:0]  rd_addr,
	output logic              clearing,
	output logic [IDX_W-1:0]  clr_addr,
	output logic              s1_valid,
	output logic [IDX_W-1:0]  s1_idx,
	output logic              s1_taken
);

	cbp_cfg_t                  cfg_q;
	logic [HIST_WIDTH_MAX-1:0] hist_q;
	logic [HIST_WIDTH_MAX-1:0] hist_mask;
	logic [ADDR_WIDTH_MAX-1:0] addr_mask;
	logic [IDX_W-1:0]          clr_q;
	logic                      clearing_q;
	logic                      accept;

	assign cfg.ready    = 1'b1;
	assign branch.ready = !clearing_q && space_ok;
	assign accept       = branch.valid && branch.ready;
	assign cfg_o        = cfg_q;
	assign clearing     = clearing_q;
	assign clr_addr     = clr_q;

	// widths above the maximum fall out as all-ones masks
	always_comb begin
		for (int i = 0; i < HIST_WIDTH_MAX; i++) begin
			hist_mask[i] = (32'(cfg_q.history_bits) > 32'(i));
		end
		for (int i = 0; i < ADDR_WIDTH_MAX; i++) begin
			addr_mask[i] = (32'(cfg_q.addr_bits) > 32'(i));
		end
	end

	assign rd_addr = {branch.branch_address[ADDR_WIDTH_MAX-1:0] & addr_mask,
		hist_q & hist_mask};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.counter_mode <= MODE_TWO_BIT;
			cfg_q.history_bits <= HIST_BITS_RESET;
			cfg_q.addr_bits    <= ADDR_BITS_RESET;
		end else if (cfg.valid) begin
			unique case (cbp_cfg_idx_t'(cfg.index))
				CFG_COUNTER_MODE: cfg_q.counter_mode <= cfg.data[0];
				CFG_HISTORY_BITS: cfg_q.history_bits <= cfg.data[2:0];
				CFG_ADDR_BITS:    cfg_q.addr_bits    <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (accept) begin
			hist_q <= HIST_WIDTH_MAX'({hist_q, branch.taken}) & hist_mask;
		end
	end

	// one table entry zeroed per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == '1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_idx   <= rd_addr;
			s1_taken <= branch.taken;
		end
	end

endmodule

>>> sv/cbp_update.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbp_update
// counter read-modify-write with forwarding, prediction and statistics
// ---------------------------------------------------------------------------
module cbp_update import cbp_pkg::*; #(
	parameter int IDX_W = CBP_ADDR_WIDTH_MAX + CBP_HIST_WIDTH_MAX
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cbp_cfg_t           cfg_i,
	input  logic               s1_valid,
	input  logic [IDX_W-1:0]   s1_idx,
	input  logic               s1_taken,
	input  logic [ENTRY_W-1:0] rd_data,
	output logic               wr_en,
	output logic [IDX_W-1:0]   wr_addr,
	output logic [ENTRY_W-1:0] wr_data,
	output logic               push,
	output cbp_result_t        result
);

	localparam int TOUCH_W = (IDX_W + 1 > ENTRIES_W) ? IDX_W + 1 : ENTRIES_W;

	logic               fwd_valid_q;
	logic [IDX_W-1:0]   fwd_idx_q;
	logic [ENTRY_W-1:0] fwd_data_q;
	logic [COUNT_W-1:0] hit_q, hit_n;
	logic [COUNT_W-1:0] br_q, br_n;
	logic [TOUCH_W-1:0] touch_q, touch_n;
	logic [ENTRY_W-1:0] cur;
	logic [CTR_W-1:0]   ctr, ctr_nxt;
	logic               pred;

	// last cycle's write lands on the same edge as this item's read
	assign cur = (fwd_valid_q && fwd_idx_q == s1_idx) ? fwd_data_q : rd_data;
	assign ctr = cur[CTR_W-1:0];

	always_comb begin
		if (cfg_i.counter_mode == MODE_ONE_BIT) begin
			pred    = (ctr == CTR_WEAK_NT);
			ctr_nxt = s1_taken ? CTR_WEAK_NT : CTR_STRONG_NT;
		end else begin
			pred = ctr[1];
			if (s1_taken) begin
				ctr_nxt = (ctr == CTR_STRONG_NT) ? CTR_WEAK_NT : CTR_STRONG_T;
			end else begin
				ctr_nxt = (ctr == CTR_STRONG_T) ? CTR_WEAK_T : CTR_STRONG_NT;
			end
		end
	end

	assign hit_n   = (s1_valid && pred == s1_taken && hit_q != '1) ? hit_q + 1'b1 : hit_q;
	assign br_n    = (s1_valid && br_q != '1) ? br_q + 1'b1 : br_q;
	assign touch_n = (s1_valid && !cur[ENTRY_W-1]) ? touch_q + 1'b1 : touch_q;

	assign wr_en   = s1_valid;
	assign wr_addr = s1_idx;
	assign wr_data = {1'b1, ctr_nxt};
	assign push    = s1_valid;

	assign result.predicted_taken = pred;
	assign result.correct_count   = hit_n;
	assign result.total_count     = br_n;
	assign result.entries_used    = ENTRIES_W'(touch_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
			hit_q       <= '0;
			br_q        <= '0;
			touch_q     <= '0;
		end else begin
			fwd_valid_q <= s1_valid;
			hit_q       <= hit_n;
			br_q        <= br_n;
			touch_q     <= touch_n;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid) begin
			fwd_idx_q  <= s1_idx;
			fwd_data_q <= wr_data;
		end
	end

endmodule

>>> sv/cbp_out_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbp_out_queue
// small result queue that decouples the pipeline from a stalling sink
// ---------------------------------------------------------------------------
module cbp_out_queue import cbp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  cbp_result_t            push_data,
	output logic [OUT_Q_CNT_W-1:0] count,
	cbp_result_if.source           result
);

	localparam int PTR_W = $clog2(OUT_Q_DEPTH);

	cbp_result_t              slot_q [OUT_Q_DEPTH];
	logic [PTR_W-1:0]         wr_ptr_q, rd_ptr_q;
	logic [OUT_Q_CNT_W-1:0]   cnt_q;
	logic                     pop;
	cbp_result_t              head;

	assign head  = slot_q[rd_ptr_q];
	assign pop   = result.valid && result.ready;
	assign count = cnt_q;

	assign result.valid           = (cnt_q != '0);
	assign result.predicted_taken = head.predicted_taken;
	assign result.correct_count   = head.correct_count;
	assign result.total_count     = head.total_count;
	assign result.entries_used    = head.entries_used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(OUT_Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(OUT_Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + OUT_Q_CNT_W'(push) - OUT_Q_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> sv/correlating_branch_predictor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// correlating_branch_predictor
// (m,n) correlating predictor over a global history and a counter table
// ---------------------------------------------------------------------------
// usage
//   branch: one resolved branch per beat (branch_address, taken)
//   result: one beat per branch with the prediction made before the update
//           and saturating correct/total counts plus touched entries
//   cfg:    register writes (counter_mode, history_bits, addr_bits), always
//           ready; write only while no branch is in flight
// timing
//   a branch beat reads the counter table in its accept cycle, the entry is
//   updated in the cycle after, and the result is queued; one branch per
//   cycle sustained while the queue has room; the table is a single ram with
//   one read and one write port, a one-deep forward covers back-to-back hits
// reset
//   configuration returns to two-bit mode, 4 history bits, 10 address bits
//   then a clearing pass zeroes the table one entry a cycle, covering all
//   2**(ADDR_WIDTH_MAX + HIST_WIDTH_MAX) entries (16384 by default), with
//   branch.ready low; cfg writes are taken during the pass
// stall
//   a three-deep result queue absorbs a stalled sink; branch.ready drops once
//   the queue plus the update stage hold three results
// ---------------------------------------------------------------------------
module correlating_branch_predictor import cbp_pkg::*; #(
	parameter int ADDR_WIDTH_MAX = CBP_ADDR_WIDTH_MAX,
	parameter int HIST_WIDTH_MAX = CBP_HIST_WIDTH_MAX
) (
	input  logic          clk,
	input  logic          arst_n,
	cbp_cfg_if.sink       cfg,
	cbp_branch_if.sink    branch,
	cbp_result_if.source  result
);

	localparam int IDX_W = ADDR_WIDTH_MAX + HIST_WIDTH_MAX;
	localparam int DEPTH = 2 ** IDX_W;

	cbp_cfg_t               cfg_cur;
	logic [IDX_W-1:0]       rd_addr;
	logic                   clearing;
	logic [IDX_W-1:0]       clr_addr;
	logic                   s1_valid;
	logic [IDX_W-1:0]       s1_idx;
	logic                   s1_taken;
	logic [ENTRY_W-1:0]     rd_data;
	logic                   upd_we;
	logic [IDX_W-1:0]       upd_addr;
	logic [ENTRY_W-1:0]     upd_data;
	logic                   push;
	cbp_result_t            push_data;
	logic [OUT_Q_CNT_W-1:0] q_count;
	logic                   space_ok;

	// ram write port: clearing pass has it alone, no branch runs then
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [ENTRY_W-1:0]     ram_wdata;

	// room for one more result counting the one already in the update stage
	assign space_ok = ({1'b0, q_count} + {{OUT_Q_CNT_W{1'b0}}, s1_valid})
		< (OUT_Q_CNT_W + 1)'(OUT_Q_DEPTH);

	assign ram_we    = clearing || upd_we;
	assign ram_waddr = clearing ? clr_addr : upd_addr;
	assign ram_wdata = clearing ? '0 : upd_data;

	cbp_front #(
		.ADDR_WIDTH_MAX (ADDR_WIDTH_MAX),
		.HIST_WIDTH_MAX (HIST_WIDTH_MAX),
		.IDX_W          (IDX_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.branch   (branch),
		.space_ok (space_ok),
		.cfg_o    (cfg_cur),
		.rd_addr  (rd_addr),
		.clearing (clearing),
		.clr_addr (clr_addr),
		.s1_valid (s1_valid),
		.s1_idx   (s1_idx),
		.s1_taken (s1_taken)
	);

	// entry: touched mark and two-bit counter
	cbp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	cbp_update #(
		.IDX_W (IDX_W)
	) u_update (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_i    (cfg_cur),
		.s1_valid (s1_valid),
		.s1_idx   (s1_idx),
		.s1_taken (s1_taken),
		.rd_data  (rd_data),
		.wr_en    (upd_we),
		.wr_addr  (upd_addr),
		.wr_data  (upd_data),
		.push     (push),
		.result   (push_data)
	);

	cbp_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.count     (q_count),
		.result    (result)
	);

endmodule

>>> sv/cbp_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbp_checker
// port-level checks of the predictor, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cbp_checker import cbp_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [COUNT_W-1:0]   correct_count,
	input logic [COUNT_W-1:0]   total_count,
	input logic [ENTRIES_W-1:0] entries_used
);

	logic [2:0] pending_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_beat) - 3'(out_beat);
		end
	end

	`ASSERT_IMPLIES(a_no_invented_result, clk, arst_n, out_valid, pending_q != 3'd0)
	`ASSERT_IMPLIES(a_inflight_bound, clk, arst_n, in_beat, pending_q < 3'd3)
	`ASSERT_IMPLIES(a_counts_ordered, clk, arst_n, out_valid, correct_count <= total_count && 32'(entries_used) <= total_count)
	`ASSERT_NEXT(a_stall_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(total_count) && $stable(correct_count))

endmodule

bind correlating_branch_predictor cbp_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (branch.valid),
	.in_ready      (branch.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.correct_count (result.correct_count),
	.total_count   (result.total_count),
	.entries_used  (result.entries_used)
);
